[sv/challenge_digest_checksum_core_macros.svh]
// Assertion macros for the checker file.
`ifndef CHALLENGE_DIGEST_CHECKSUM_CORE_MACROS_SVH
`define CHALLENGE_DIGEST_CHECKSUM_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[sv/cdc_pkg.sv]
// Package with digest constants, tables and types for the checksum block.
`default_nettype none
package cdc_pkg;
  localparam int unsigned ChallengeBytesDef = 4;
  localparam logic [31:0] ExtReset = 32'd20161130;
  localparam logic [31:0] LegacyLo = 32'd20000711;
  localparam logic [31:0] LegacyHi = 32'd126;

  typedef enum logic [1:0] {
    MODE_LEGACY = 2'd0,
    MODE_MD5    = 2'd1,
    MODE_MD4    = 2'd2,
    MODE_SHA1   = 2'd3
  } mode_e;

  typedef struct packed {
    logic  load;
    logic  step;
    logic  sched;
    logic  finish;
    logic  [6:0] round;
    mode_e mode;
  } cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] w;
    w = {x, x} << s;
    return w[63:32];
  endfunction

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_s(input logic [3:0] i);
    logic [4:0] s;
    case (i)
      4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
      4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
      4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] md4_s(input logic [3:0] i);
    logic [4:0] s;
    case (i)
      4'd0: s = 5'd3;  4'd1: s = 5'd7;  4'd2: s = 5'd11; 4'd3: s = 5'd19;
      4'd4: s = 5'd3;  4'd5: s = 5'd5;  4'd6: s = 5'd9;  4'd7: s = 5'd13;
      4'd8: s = 5'd3;  4'd9: s = 5'd9;  4'd10: s = 5'd11; default: s = 5'd15;
    endcase
    return s;
  endfunction

  // Message word index for MD4 round i (i below 48).
  function automatic logic [3:0] md4_ord(input logic [5:0] i);
    logic [3:0] j;
    j = i[3:0];
    case (i[5:4])
      2'd0: md4_ord = j;
      2'd1: md4_ord = {j[1:0], j[3:2]};
      default: md4_ord = {j[0], j[1], j[2], j[3]};
    endcase
  endfunction

  // Digest byte index for checksum byte n.
  function automatic logic [4:0] sel_idx(input mode_e m, input logic [2:0] n);
    logic [4:0] r;
    r = 5'd0;
    case (m)
      MODE_MD4: case (n)
        3'd0: r = 5'd1; 3'd1: r = 5'd2; 3'd2: r = 5'd8; 3'd3: r = 5'd9;
        3'd4: r = 5'd4; 3'd5: r = 5'd5; 3'd6: r = 5'd11; default: r = 5'd12;
      endcase
      MODE_MD5: case (n)
        3'd0: r = 5'd2; 3'd1: r = 5'd3; 3'd2: r = 5'd8; 3'd3: r = 5'd9;
        3'd4: r = 5'd5; 3'd5: r = 5'd6; 3'd6: r = 5'd13; default: r = 5'd14;
      endcase
      default: case (n)
        3'd0: r = 5'd2; 3'd1: r = 5'd3; 3'd2: r = 5'd9; 3'd3: r = 5'd10;
        3'd4: r = 5'd5; 3'd5: r = 5'd6; 3'd6: r = 5'd15; default: r = 5'd16;
      endcase
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

[sv/cdc_datapath.sv]
// Shared round datapath for MD4, MD5 and SHA-1 over one padded block.
`default_nettype none
module cdc_datapath #(
  parameter int unsigned ChallengeBytes = cdc_pkg::ChallengeBytesDef
) (
  input  wire logic          clk_i,
  input  wire cdc_pkg::cmd_t cmd_i,
  input  wire logic [31:0]   challenge_i,
  input  wire logic [31:0]   ext_i,
  output logic [63:0]        checksum_o
);
  import cdc_pkg::*;

  localparam int unsigned MsgLen = ChallengeBytes + 4;
  localparam logic [15:0] MsgBits = 16'(MsgLen * 8);

  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] a_d, b_d, c_d, d_d, e_d;
  logic [63:0] sum_q, sum_d;

  logic [7:0]  blk [64];
  logic [31:0] f, k, t, xw, sw;
  logic [5:0]  ri;
  logic [6:0]  i;
  logic [159:0] dig;
  logic [7:0]  db;
  logic [4:0]  si;

  assign i  = cmd_i.round;
  assign ri = i[5:0];

  always_comb begin
    for (int n = 0; n < 64; n++) blk[n] = 8'h00;
    for (int n = 0; n < ChallengeBytes && n < 4; n++) blk[n] = challenge_i[8*n +: 8];
    for (int n = 0; n < 4; n++) blk[ChallengeBytes + n] = ext_i[8*n +: 8];
    blk[MsgLen] = 8'h80;
    if (cmd_i.mode == MODE_SHA1) begin
      blk[63] = MsgBits[7:0];
      blk[62] = MsgBits[15:8];
    end else begin
      blk[56] = MsgBits[7:0];
      blk[57] = MsgBits[15:8];
    end
  end

  // SHA-1 schedule word that enters the end of the 16-word window.
  assign sw = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 5'd1);

  always_comb begin
    f = 32'h0; k = 32'h0; xw = 32'h0; t = 32'h0;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q;
    for (int n = 0; n < 16; n++) w_d[n] = w_q[n];
    sum_d = sum_q;
    dig = '0;
    db = 8'h0;
    si = 5'd0;
    if (cmd_i.load) begin
      for (int n = 0; n < 16; n++) begin
        if (cmd_i.mode == MODE_SHA1) begin
          w_d[n] = {blk[4*n], blk[4*n+1], blk[4*n+2], blk[4*n+3]};
        end else begin
          w_d[n] = {blk[4*n+3], blk[4*n+2], blk[4*n+1], blk[4*n]};
        end
      end
      a_d = 32'h67452301; b_d = 32'hefcdab89; c_d = 32'h98badcfe;
      d_d = 32'h10325476; e_d = 32'hc3d2e1f0;
      sum_d = (cmd_i.mode == MODE_LEGACY) ? {LegacyHi, LegacyLo} : 64'h0;
    end else if (cmd_i.step) begin
      case (cmd_i.mode)
        MODE_MD4: begin
          xw = w_q[md4_ord(ri)];
          case (ri[5:4])
            2'd0: f = (b_q & c_q) | (~b_q & d_q);
            2'd1: f = ((b_q & c_q) | (b_q & d_q) | (c_q & d_q)) + 32'h5a827999;
            default: f = (b_q ^ c_q ^ d_q) + 32'h6ed9eba1;
          endcase
          t = rotl(a_q + f + xw, md4_s({ri[5:4], ri[1:0]}));
          a_d = d_q; d_d = c_q; c_d = b_q; b_d = t;
        end
        MODE_MD5: begin
          case (ri[5:4])
            2'd0: begin f = (b_q & c_q) | (~b_q & d_q); xw = w_q[ri[3:0]]; end
            2'd1: begin
              f = (d_q & b_q) | (~d_q & c_q);
              xw = w_q[4'(ri[3:0] * 4'd5 + 4'd1)];
            end
            2'd2: begin
              f = b_q ^ c_q ^ d_q;
              xw = w_q[4'(ri[3:0] * 4'd3 + 4'd5)];
            end
            default: begin
              f = c_q ^ (b_q | ~d_q);
              xw = w_q[4'(ri[3:0] * 4'd7)];
            end
          endcase
          t = f + a_q + md5_k(ri) + xw;
          a_d = d_q; d_d = c_q; c_d = b_q;
          b_d = b_q + rotl(t, md5_s({ri[5:4], ri[1:0]}));
        end
        default: begin
          if (i < 7'd20) begin
            f = (b_q & c_q) | (~b_q & d_q); k = 32'h5a827999;
          end else if (i < 7'd40) begin
            f = b_q ^ c_q ^ d_q; k = 32'h6ed9eba1;
          end else if (i < 7'd60) begin
            f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8f1bbcdc;
          end else begin
            f = b_q ^ c_q ^ d_q; k = 32'hca62c1d6;
          end
          t = rotl(a_q, 5'd5) + f + e_q + k + w_q[0];
          e_d = d_q; d_d = c_q; c_d = rotl(b_q, 5'd30); b_d = a_q; a_d = t;
          for (int n = 0; n < 15; n++) w_d[n] = w_q[n+1];
          w_d[15] = sw;
        end
      endcase
    end else if (cmd_i.finish) begin
      // Add the initial chaining values back in.
      a_d = a_q + 32'h67452301; b_d = b_q + 32'hefcdab89;
      c_d = c_q + 32'h98badcfe; d_d = d_q + 32'h10325476;
      e_d = e_q + 32'hc3d2e1f0;
    end else if (cmd_i.sched) begin
      // Gather one checksum byte per cycle; round carries the byte number.
      if (cmd_i.mode == MODE_SHA1) begin
        dig = {e_q, d_q, c_q, b_q, a_q};
        for (int n = 0; n < 5; n++) begin
          dig[32*n +: 32] = {dig[32*n +: 8], dig[32*n+8 +: 8],
                             dig[32*n+16 +: 8], dig[32*n+24 +: 8]};
        end
      end else begin
        dig = {32'h0, d_q, c_q, b_q, a_q};
      end
      si = sel_idx(cmd_i.mode, i[2:0]);
      db = dig[8*si +: 8];
      sum_d[8*i[2:0] +: 8] = db;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d;
    sum_q <= sum_d;
    for (int n = 0; n < 16; n++) w_q[n] <= w_d[n];
  end

  assign checksum_o = sum_q;
endmodule
`default_nettype wire

[sv/cdc_ctrl.sv]
// Controller sequencing load, rounds, finish and byte gathering.
`default_nettype none
module cdc_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic        out_stall_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  output logic [1:0]       mode_o,
  output cdc_pkg::cmd_t    cmd_o
);
  import cdc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_ROUND, S_FINISH, S_GATHER, S_OUT} state_e;

  state_e state_q;
  mode_e  mode_q;
  logic [6:0] cnt_q;
  logic [6:0] last;

  always_comb begin
    case (mode_q)
      MODE_MD4: last = 7'd47;
      MODE_MD5: last = 7'd63;
      default:  last = 7'd79;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign mode_o      = mode_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.mode   = mode_q;
    cmd_o.round  = cnt_q;
    cmd_o.load   = (state_q == S_LOAD);
    cmd_o.step   = (state_q == S_ROUND);
    cmd_o.finish = (state_q == S_FINISH);
    cmd_o.sched  = (state_q == S_GATHER);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_LEGACY;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          mode_q  <= mode_e'(mode_i);
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          cnt_q   <= '0;
          state_q <= (mode_q == MODE_LEGACY) ? S_OUT : S_ROUND;
        end
        S_ROUND: begin
          if (cnt_q == last) begin
            state_q <= S_FINISH;
          end
          cnt_q <= cnt_q + 7'd1;
        end
        S_FINISH: begin
          cnt_q   <= '0;
          state_q <= S_GATHER;
        end
        S_GATHER: begin
          if (cnt_q == 7'd7) state_q <= S_OUT;
          cnt_q <= cnt_q + 7'd1;
        end
        S_OUT: if (!out_stall_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[sv/challenge_digest_checksum_core.sv]
// Top level of the challenge digest checksum block.
// Usage: a request on the input channel carries a 32-bit challenge; it is
// accepted when in_valid is high and in_stall is low. The low two bits of
// challenge byte 0 choose the digest: 1 MD5, 2 MD4, 3 SHA-1, 0 legacy words.
// The extension word register is written on the cfg channel (valid and
// ready); ready is high whenever the block is idle, and it resets to 20161130.
// One request is in flight at a time: the challenge is held from acceptance
// until the result leaves. After acceptance the controller runs a load step;
// in legacy mode out_valid follows it, otherwise it runs the rounds of the
// chosen digest (48 for MD4, 64 for MD5, 80 for SHA-1) on the single shared
// round unit that does one round per cycle, then a finish step and the
// gathering of eight checksum bytes before out_valid is raised.
// The result sits in the output register while out_stall is high and the
// block takes no new request until it has been taken.
// Reset is asynchronous and active low; it returns the controller to idle
// and restores the extension word.
`default_nettype none
module challenge_digest_checksum_core #(
  parameter int unsigned ChallengeBytes = cdc_pkg::ChallengeBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] challenge_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      checksum_o,
  output logic [1:0]       mode_used_o
);
  import cdc_pkg::*;

  cmd_t        cmd;
  logic [31:0] ext_q, chal_q;

  // The configuration port is open only while no request is in flight.
  assign cfg_ready_o = !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q <= ExtReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ext_q <= cfg_data_i;
    end
  end

  // Held challenge feeds the message block during the load cycle.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) chal_q <= challenge_i;
  end

  cdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (challenge_i[1:0]),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .mode_o      (mode_used_o),
    .cmd_o       (cmd)
  );

  cdc_datapath #(.ChallengeBytes(ChallengeBytes)) u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .challenge_i (chal_q),
    .ext_i       (ext_q),
    .checksum_o  (checksum_o)
  );
endmodule
`default_nettype wire

[sv/cdc_checker.sv]
// Port-level checker for the checksum block, bound to the top level.
`default_nettype none
`include "challenge_digest_checksum_core_macros.svh"
module cdc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        cfg_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] checksum_o,
  input wire logic [1:0]  mode_used_o
);
  import cdc_pkg::*;

  `CDC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `CDC_ASSERT_IMP(a_out_busy, clk_i, rst_ni, out_valid_o, in_stall_o && !cfg_ready_o)
  `CDC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(checksum_o) && $stable(mode_used_o))
  `CDC_ASSERT_IMP(a_legacy, clk_i, rst_ni, out_valid_o && mode_used_o == MODE_LEGACY,
    checksum_o == {LegacyHi, LegacyLo})
endmodule
bind challenge_digest_checksum_core cdc_checker u_cdc_checker (.*);
`default_nettype wire

[test/tb_challenge_digest_checksum_core.sv]
// Self-checking testbench for the challenge digest checksum core.
`default_nettype none
module tb_challenge_digest_checksum_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cdc_pkg::*;

  // The watchdog ends the run after this many cycles in which no request,
  // result or register write is accepted. The slowest request is a SHA-1
  // digest, and a result can also wait out a long run of receiver stalls.
  localparam int unsigned IdleLimit = 5000;
  // Settling time after the last result, well past the longest latency.
  localparam int unsigned DrainCycles = 120;

  // One expected result: the checksum and the digest mode that produced it.
  typedef struct {
    logic [63:0] checksum;
    mode_e       mode;
  } checksum_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] challenge_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] checksum_o;
  logic [1:0]  mode_used_o;

  challenge_digest_checksum_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .challenge_i (challenge_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .checksum_o  (checksum_o),
    .mode_used_o (mode_used_o)
  );

  always #1 clk_i = ~clk_i;

  // Testbench copy of the extension word register.
  logic [31:0]   ext_word = ExtReset;
  checksum_rec_t pending_sums[$];
  int unsigned   mismatches = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;

  // Round constants and tables for the three digests.
  localparam logic [31:0] Md5K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int Md5Shift [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
  localparam int Md4Shift [12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};
  localparam int Md4Word [48] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
    0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15,
    0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15};
  localparam int PickMd4 [8]  = '{1, 2, 8, 9, 4, 5, 11, 12};
  localparam int PickMd5 [8]  = '{2, 3, 8, 9, 5, 6, 13, 14};
  localparam int PickSha1 [8] = '{2, 3, 9, 10, 5, 6, 15, 16};

  function automatic logic [31:0] rot_left(input logic [31:0] x, input int s);
    return (s == 0) ? x : ((x << s) | (x >> (32 - s)));
  endfunction

  // Computes the checksum the block must return for one challenge.
  function automatic checksum_rec_t predict_checksum(input logic [31:0] ch,
                                                     input logic [31:0] ext);
    checksum_rec_t rec;
    logic [7:0]    blk [64];
    logic [7:0]    dig [20];
    logic [31:0]   x [16];
    logic [31:0]   w [80];
    logic [31:0]   h [5];
    logic [31:0]   a, b, c, d, e, f, k, t;
    logic [63:0]   bits;
    int            g;
    bits = 64'd64;
    rec.mode = mode_e'(ch[1:0]);
    rec.checksum = '0;
    foreach (blk[i]) blk[i] = 8'h00;
    foreach (dig[i]) dig[i] = 8'h00;
    for (int i = 0; i < 4; i++) begin
      blk[i] = ch[8*i +: 8];
      blk[4 + i] = ext[8*i +: 8];
    end
    blk[8] = 8'h80;
    h = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0};
    case (rec.mode)
      MODE_LEGACY: begin
        rec.checksum = {LegacyHi, LegacyLo};
        return rec;
      end
      MODE_SHA1: begin
        // SHA-1 stores the bit length big-endian and reads words big-endian.
        for (int i = 0; i < 8; i++) blk[63 - i] = bits[8*i +: 8];
        for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 80; i++) w[i] = rot_left(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
        for (int i = 0; i < 80; i++) begin
          if (i < 20)      begin f = (b & c) | (~b & d);          k = 32'h5a827999; end
          else if (i < 40) begin f = b ^ c ^ d;                   k = 32'h6ed9eba1; end
          else if (i < 60) begin f = (b & c) | (b & d) | (c & d); k = 32'h8f1bbcdc; end
          else             begin f = b ^ c ^ d;                   k = 32'hca62c1d6; end
          t = rot_left(a, 5) + f + e + k + w[i];
          e = d; d = c; c = rot_left(b, 30); b = a; a = t;
        end
        h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
        for (int i = 0; i < 5; i++)
          for (int j = 0; j < 4; j++) dig[4*i + j] = h[i][8*(3-j) +: 8];
        for (int i = 0; i < 8; i++) rec.checksum[8*i +: 8] = dig[PickSha1[i]];
      end
      default: begin
        // MD4 and MD5 share the little-endian length and word order.
        for (int i = 0; i < 8; i++) blk[56 + i] = bits[8*i +: 8];
        for (int i = 0; i < 16; i++) x[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        a = h[0]; b = h[1]; c = h[2]; d = h[3];
        if (rec.mode == MODE_MD4) begin
          for (int i = 0; i < 48; i++) begin
            if (i < 16)      f = (b & c) | (~b & d);
            else if (i < 32) f = ((b & c) | (b & d) | (c & d)) + 32'h5a827999;
            else             f = (b ^ c ^ d) + 32'h6ed9eba1;
            t = rot_left(a + f + x[Md4Word[i]], Md4Shift[(i / 16) * 4 + (i % 4)]);
            a = d; d = c; c = b; b = t;
          end
        end else begin
          for (int i = 0; i < 64; i++) begin
            if (i < 16)      begin f = (b & c) | (~b & d); g = i;             end
            else if (i < 32) begin f = (d & b) | (~d & c); g = 5 * i + 1;     end
            else if (i < 48) begin f = b ^ c ^ d;          g = 3 * i + 5;     end
            else             begin f = c ^ (b | ~d);       g = 7 * i;         end
            f = f + a + Md5K[i] + x[g % 16];
            a = d; d = c; c = b;
            b = b + rot_left(f, Md5Shift[(i / 16) * 4 + (i % 4)]);
          end
        end
        h[0] += a; h[1] += b; h[2] += c; h[3] += d;
        for (int i = 0; i < 4; i++)
          for (int j = 0; j < 4; j++) dig[4*i + j] = h[i][8*j +: 8];
        for (int i = 0; i < 8; i++)
          rec.checksum[8*i +: 8] = (rec.mode == MODE_MD4) ? dig[PickMd4[i]] : dig[PickMd5[i]];
      end
    endcase
    return rec;
  endfunction

  // Receiver stalls are redrawn every cycle from the current stall rate.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result checker and watchdog. Outputs are sampled at the edge, before
  // the block's registers update, so the sample matches what the DUT saw.
  always @(posedge clk_i) begin
    checksum_rec_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("tb_challenge_digest_checksum_core failed");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_sums.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: checksum %h mode %0d", checksum_o, mode_used_o);
        end else begin
          want = pending_sums.pop_front();
          if (checksum_o !== want.checksum || mode_used_o !== want.mode) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected checksum %h mode %0d, got checksum %h mode %0d",
                       want.checksum, want.mode, checksum_o, mode_used_o);
          end
        end
      end
    end
  end

  // Sends one challenge request and records its expected result. Valid is
  // dropped right after acceptance.
  task automatic send_challenge(input logic [31:0] ch);
    @(posedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i  <= 1'b1;
    challenge_i <= ch;
    do @(posedge clk_i); while (in_stall_o);
    pending_sums.push_back(predict_checksum(ch, ext_word));
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_sums.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Writes the extension word once the block holds no request.
  task automatic write_extension(input logic [31:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    ext_word = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] random_challenge();
    return $urandom();
  endfunction

  // Extremes of the challenge and every mode under the reset extension word.
  task automatic test_directed_modes();
    logic [31:0] fixed_set [12];
    fixed_set = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_fffc, 32'h0000_0003,
                  32'h0000_0001, 32'h0000_0002, 32'h8000_0001, 32'h7fff_fffe,
                  32'haaaa_aaab, 32'h5555_5555, 32'h0102_0302, 32'hfedc_ba98};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (fixed_set[i]) send_challenge(fixed_set[i]);
  endtask

  // Extension word extremes, each with every mode.
  task automatic test_extension_extremes();
    logic [31:0] ext_set [3];
    ext_set = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0001};
    foreach (ext_set[i]) begin
      write_extension(ext_set[i]);
      for (int m = 0; m < 4; m++) send_challenge({random_challenge()} & ~32'h3 | m);
    end
  endtask

  // Random challenges under one idle and stall setting and a given extension word.
  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input logic [31:0] ext, input int unsigned count);
    write_extension(ext);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_challenge(random_challenge());
  endtask

  // The sender holds off until every result is back, then resumes.
  task automatic test_drain_pause();
    send_idle_pct = 7;
    recv_stall_pct = 7;
    for (int i = 0; i < 10; i++) begin
      send_challenge(random_challenge());
      if (i == 4) wait_drained();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_modes();
    test_extension_extremes();
    test_random_phase(0, 0, $urandom(), 130);
    test_random_phase(48, 0, $urandom(), 130);
    test_random_phase(0, 48, ExtReset, 130);
    test_random_phase(7, 7, $urandom(), 130);
    test_drain_pause();
    wait_drained();
    recv_stall_pct = 0;
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_sums.size() == 0)
      $display("tb_challenge_digest_checksum_core passed");
    else
      $display("tb_challenge_digest_checksum_core failed");
    $finish;
  end
endmodule
`default_nettype wire
